/* sv/pfs_pkg.sv */
`timescale 1ns / 1ps
package pfs_pkg;

    localparam int NUM_FRONT   = 8;
    localparam int NUM_BACK    = 8;
    localparam int FRONT_DEPTH = 16;
    localparam int BACK_DEPTH  = 16;
    localparam int ROUTE_LIMIT = 8;

    localparam int FQ_W = (NUM_FRONT > 1) ? $clog2(NUM_FRONT) : 1;
    localparam int BQ_W = (NUM_BACK > 1) ? $clog2(NUM_BACK) : 1;
    localparam int FP_W = $clog2(FRONT_DEPTH);
    localparam int BP_W = $clog2(BACK_DEPTH);
    localparam int FC_W = $clog2(FRONT_DEPTH + 1);
    localparam int BC_W = $clog2(BACK_DEPTH + 1);
    localparam int FA_W = $clog2(NUM_FRONT * FRONT_DEPTH);
    localparam int BA_W = $clog2(NUM_BACK * BACK_DEPTH);
    localparam int RL_W = $clog2(ROUTE_LIMIT + 1);

    localparam int ENTRY_W = 48;
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd5000000;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_CHK,
        S_SCAN,
        S_PREAD,
        S_POUT,
        S_RSTART,
        S_RITEM,
        S_RWAIT
    } state_t;

    // pointer wrap for the queue rings
    function automatic logic [FP_W-1:0] fwrap(input logic [FP_W-1:0] p);
        fwrap = (p == FP_W'(FRONT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [BP_W-1:0] bwrap(input logic [BP_W-1:0] p);
        bwrap = (p == BP_W'(BACK_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // flat memory addresses
    function automatic logic [FA_W-1:0] faddr(input logic [FQ_W-1:0] q,
                                              input logic [FP_W-1:0] p);
        faddr = FA_W'(FA_W'(q) * FA_W'(FRONT_DEPTH) + FA_W'(p));
    endfunction

    function automatic logic [BA_W-1:0] baddr(input logic [BQ_W-1:0] q,
                                              input logic [BP_W-1:0] p);
        baddr = BA_W'(BA_W'(q) * BA_W'(BACK_DEPTH) + BA_W'(p));
    endfunction

endpackage

/* sv/polite_host_frontier_scheduler.sv */
`timescale 1ns / 1ps
// Polite host frontier scheduler.
// Input channel (in_valid / in_stall): one word per request, op 0 pushes
// {item_id, host_key} into front queue priority_req, op 1 pops the next item.
// Output channel (out_valid / out_stall): exactly one result word per
// request: status, popped item, host and its scheduled fetch_time.
// cfg_wr_en / cfg_wr_data write politeness_delay (reset 5000000).
// One request is in flight at a time; in_stall is high while it works.
// A push writes its front queue memory directly. A pop with a scheduled back
// queue runs a serial least-ready scan, then one read of the back queue
// memory. A routing pass visits front queues and moves items (front memory
// read, then write back); it runs before a pop when nothing is scheduled and
// after a pop that empties a back queue.
// A result waits in the output register while out_stall is high; the next
// request is still taken meanwhile, and only its result step waits.
// Reset empties every queue; the queue memories need no clearing.
module polite_host_frontier_scheduler
    import pfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [DELAY_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [31:0]         item_id,
    input  logic [15:0]         host_key,
    input  logic [7:0]          priority_req,
    input  logic                item_ok,
    input  logic [TIME_W-1:0]   now_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [31:0]         out_item_id,
    output logic [15:0]         out_host_key,
    output logic [TIME_W-1:0]   fetch_time
);

    state_t state_reg, state_next;

    logic [FP_W-1:0]   fhead_reg [NUM_FRONT];
    logic [FP_W-1:0]   fhead_next [NUM_FRONT];
    logic [FP_W-1:0]   ftail_reg [NUM_FRONT];
    logic [FP_W-1:0]   ftail_next [NUM_FRONT];
    logic [FC_W-1:0]   fcount_reg [NUM_FRONT];
    logic [FC_W-1:0]   fcount_next [NUM_FRONT];
    logic [BP_W-1:0]   bhead_reg [NUM_BACK];
    logic [BP_W-1:0]   bhead_next [NUM_BACK];
    logic [BP_W-1:0]   btail_reg [NUM_BACK];
    logic [BP_W-1:0]   btail_next [NUM_BACK];
    logic [BC_W-1:0]   bcount_reg [NUM_BACK];
    logic [BC_W-1:0]   bcount_next [NUM_BACK];
    logic [15:0]       bowner_reg [NUM_BACK];
    logic [15:0]       bowner_next [NUM_BACK];
    logic [TIME_W-1:0] bready_reg [NUM_BACK];
    logic [TIME_W-1:0] bready_next [NUM_BACK];

    logic [31:0]       id_reg, id_next;
    logic [15:0]       host_reg, host_next;
    logic [7:0]        prio_reg, prio_next;
    logic              ok_reg, ok_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [FQ_W:0]     pos_reg, pos_next;
    logic [RL_W-1:0]   limit_reg, limit_next;
    logic [FC_W-1:0]   left_reg, left_next;
    logic [FQ_W-1:0]   q_reg, q_next;
    logic              ret_reg, ret_next;
    logic [BQ_W-1:0]   scan_reg, scan_next;
    logic [BQ_W-1:0]   best_reg, best_next;
    logic              bv_reg, bv_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       oid_reg, oid_next;
    logic [15:0]       ohost_reg, ohost_next;
    logic [TIME_W-1:0] otime_reg, otime_next;

    logic                f_we, b_we;
    logic [FA_W-1:0]     f_waddr, f_raddr;
    logic [BA_W-1:0]     b_waddr, b_raddr;
    logic [ENTRY_W-1:0]  f_wdata, f_rdata, b_wdata, b_rdata;

    logic              can_load, any_back, accept;
    logic              hit, free;
    logic [BQ_W-1:0]   hit_idx, free_idx;
    logic [15:0]       r_host;
    logic              prio_ok;
    logic [FQ_W-1:0]   pq;
    logic [TIME_W:0]   ready_sum;

    assign can_load = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign prio_ok  = (32'(prio_reg) < NUM_FRONT);
    assign pq       = FQ_W'(prio_reg);
    assign r_host   = f_rdata[15:0];
    assign ready_sum = {1'b0, bready_reg[best_reg]} + (TIME_W + 1)'(delay_reg);

    // queue memories
    assign f_raddr = faddr(q_reg, fhead_reg[q_reg]);
    assign b_raddr = baddr(best_reg, bhead_reg[best_reg]);

    pfs_ram #(.W(ENTRY_W), .A_W(FA_W), .DEPTH(NUM_FRONT * FRONT_DEPTH)) u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    pfs_ram #(.W(ENTRY_W), .A_W(BA_W), .DEPTH(NUM_BACK * BACK_DEPTH)) u_back_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // occupancy, host match and free back queue, all in parallel
    always_comb
    begin
        any_back = 1'b0;
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int b = 0; b < NUM_BACK; b++)
        begin
            if (bcount_reg[b] != '0)
            begin
                any_back = 1'b1;
            end
            if (!hit && bcount_reg[b] != '0 && bowner_reg[b] == r_host)
            begin
                hit     = 1'b1;
                hit_idx = BQ_W'(b);
            end
            if (!free && bcount_reg[b] == '0)
            begin
                free     = 1'b1;
                free_idx = BQ_W'(b);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = op ? S_POP : S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                state_next = any_back ? S_SCAN : S_RSTART;
            end
            S_CHK:
            begin
                if (any_back)
                begin
                    state_next = S_SCAN;
                end
                else if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == BQ_W'(NUM_BACK - 1))
                begin
                    state_next = S_PREAD;
                end
            end
            S_PREAD:
            begin
                state_next = S_POUT;
            end
            S_POUT:
            begin
                if (can_load)
                begin
                    state_next = (bcount_reg[best_reg] == BC_W'(1)) ? S_RSTART : S_IDLE;
                end
            end
            S_RSTART:
            begin
                if (pos_reg == '0 || limit_reg == '0)
                begin
                    state_next = ret_reg ? S_CHK : S_IDLE;
                end
                else
                begin
                    state_next = S_RITEM;
                end
            end
            S_RITEM:
            begin
                if (left_reg == '0 || fcount_reg[q_reg] == '0)
                begin
                    state_next = S_RSTART;
                end
                else
                begin
                    state_next = S_RWAIT;
                end
            end
            S_RWAIT:
            begin
                state_next = S_RITEM;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fhead_next  = fhead_reg;
        ftail_next  = ftail_reg;
        fcount_next = fcount_reg;
        bhead_next  = bhead_reg;
        btail_next  = btail_reg;
        bcount_next = bcount_reg;
        bowner_next = bowner_reg;
        bready_next = bready_reg;
        id_next     = id_reg;
        host_next   = host_reg;
        prio_next   = prio_reg;
        ok_next     = ok_reg;
        now_next    = now_reg;
        delay_next  = cfg_wr_en ? cfg_wr_data : delay_reg;
        pos_next    = pos_reg;
        limit_next  = limit_reg;
        left_next   = left_reg;
        q_next      = q_reg;
        ret_next    = ret_reg;
        scan_next   = scan_reg;
        best_next   = best_reg;
        bv_next     = bv_reg;
        out_valid_next = (out_valid_reg && out_stall) ? 1'b1 : 1'b0;
        status_next = status_reg;
        oid_next    = oid_reg;
        ohost_next  = ohost_reg;
        otime_next  = otime_reg;
        f_we    = 1'b0;
        f_waddr = faddr(q_reg, ftail_reg[q_reg]);
        f_wdata = f_rdata;
        b_we    = 1'b0;
        b_waddr = '0;
        b_wdata = f_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next   = item_id;
                    host_next = host_key;
                    prio_next = priority_req;
                    ok_next   = item_ok;
                    now_next  = now_time;
                end
            end
            S_PUSH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    oid_next   = '0;
                    ohost_next = '0;
                    otime_next = '0;
                    if (!ok_reg || !prio_ok)
                    begin
                        status_next = ST_BAD;
                    end
                    else if (fcount_reg[pq] >= FC_W'(FRONT_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next     = ST_OK;
                        f_we            = 1'b1;
                        f_waddr         = faddr(pq, ftail_reg[pq]);
                        f_wdata         = {id_reg, host_reg};
                        ftail_next[pq]  = fwrap(ftail_reg[pq]);
                        fcount_next[pq] = fcount_reg[pq] + 1'b1;
                    end
                end
            end
            S_POP:
            begin
                scan_next  = '0;
                bv_next    = 1'b0;
                ret_next   = 1'b1;
                pos_next   = (FQ_W + 1)'(NUM_FRONT);
                limit_next = RL_W'(ROUTE_LIMIT);
            end
            S_CHK:
            begin
                scan_next = '0;
                bv_next   = 1'b0;
                if (!any_back && can_load)
                begin
                    out_valid_next = 1'b1;
                    status_next = ST_EMPTY;
                    oid_next    = '0;
                    ohost_next  = '0;
                    otime_next  = '0;
                end
            end
            S_SCAN:
            begin
                // least ready time, lowest index on a tie
                if (bcount_reg[scan_reg] != '0 &&
                    (!bv_reg || bready_reg[scan_reg] < bready_reg[best_reg]))
                begin
                    best_next = scan_reg;
                    bv_next   = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            S_PREAD:
            begin
            end
            S_POUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    status_next = ST_OK;
                    oid_next    = b_rdata[47:16];
                    ohost_next  = b_rdata[15:0];
                    otime_next  = bready_reg[best_reg];
                    bhead_next[best_reg]  = bwrap(bhead_reg[best_reg]);
                    bcount_next[best_reg] = bcount_reg[best_reg] - 1'b1;
                    if (bcount_reg[best_reg] == BC_W'(1))
                    begin
                        bowner_next[best_reg] = '0;
                        ret_next   = 1'b0;
                        pos_next   = (FQ_W + 1)'(NUM_FRONT);
                        limit_next = RL_W'(ROUTE_LIMIT);
                    end
                    else
                    begin
                        bready_next[best_reg] = ready_sum[TIME_W] ? '1 : ready_sum[TIME_W-1:0];
                    end
                end
            end
            S_RSTART:
            begin
                if (pos_reg != '0 && limit_reg != '0)
                begin
                    q_next     = FQ_W'(pos_reg - 1'b1);
                    pos_next   = pos_reg - 1'b1;
                    limit_next = limit_reg - 1'b1;
                    left_next  = fcount_reg[FQ_W'(pos_reg - 1'b1)];
                end
            end
            S_RITEM:
            begin
                if (left_reg != '0 && fcount_reg[q_reg] != '0)
                begin
                    fhead_next[q_reg]  = fwrap(fhead_reg[q_reg]);
                    fcount_next[q_reg] = fcount_reg[q_reg] - 1'b1;
                    left_next          = left_reg - 1'b1;
                end
            end
            S_RWAIT:
            begin
                if (hit && bcount_reg[hit_idx] < BC_W'(BACK_DEPTH))
                begin
                    b_we    = 1'b1;
                    b_waddr = baddr(hit_idx, btail_reg[hit_idx]);
                    btail_next[hit_idx]  = bwrap(btail_reg[hit_idx]);
                    bcount_next[hit_idx] = bcount_reg[hit_idx] + 1'b1;
                end
                else if (!hit && free)
                begin
                    b_we    = 1'b1;
                    b_waddr = baddr(free_idx, btail_reg[free_idx]);
                    bowner_next[free_idx] = r_host;
                    bready_next[free_idx] = now_reg;
                    btail_next[free_idx]  = bwrap(btail_reg[free_idx]);
                    bcount_next[free_idx] = bcount_reg[free_idx] + 1'b1;
                end
                else
                begin
                    // no room: rotate to the tail of its front queue
                    f_we = 1'b1;
                    ftail_next[q_reg]  = fwrap(ftail_reg[q_reg]);
                    fcount_next[q_reg] = fcount_reg[q_reg] + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            delay_reg     <= DELAY_RESET;
            for (int i = 0; i < NUM_FRONT; i++)
            begin
                fhead_reg[i]  <= '0;
                ftail_reg[i]  <= '0;
                fcount_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_BACK; i++)
            begin
                bhead_reg[i]  <= '0;
                btail_reg[i]  <= '0;
                bcount_reg[i] <= '0;
                bowner_reg[i] <= '0;
                bready_reg[i] <= '0;
            end
            pos_reg   <= '0;
            limit_reg <= '0;
            left_reg  <= '0;
            q_reg     <= '0;
            ret_reg   <= 1'b0;
            scan_reg  <= '0;
            best_reg  <= '0;
            bv_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            delay_reg     <= delay_next;
            fhead_reg     <= fhead_next;
            ftail_reg     <= ftail_next;
            fcount_reg    <= fcount_next;
            bhead_reg     <= bhead_next;
            btail_reg     <= btail_next;
            bcount_reg    <= bcount_next;
            bowner_reg    <= bowner_next;
            bready_reg    <= bready_next;
            pos_reg       <= pos_next;
            limit_reg     <= limit_next;
            left_reg      <= left_next;
            q_reg         <= q_next;
            ret_reg       <= ret_next;
            scan_reg      <= scan_next;
            best_reg      <= best_next;
            bv_reg        <= bv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        host_reg   <= host_next;
        prio_reg   <= prio_next;
        ok_reg     <= ok_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        oid_reg    <= oid_next;
        ohost_reg  <= ohost_next;
        otime_reg  <= otime_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_item_id  = oid_reg;
    assign out_host_key = ohost_reg;
    assign fetch_time   = otime_reg;

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request taken but block did not start");

    a_back_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RWAIT && b_we && hit) |-> bcount_reg[hit_idx] < BC_W'(BACK_DEPTH))
        else $error("back queue written beyond its depth");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (out_item_id == '0 && fetch_time == '0))
        else $error("empty frontier word carries data");

endmodule

/* sv/pfs_ram.sv */
`timescale 1ns / 1ps
module pfs_ram #(
    parameter int W     = 48,
    parameter int A_W   = 7,
    parameter int DEPTH = 128
) (
    input  logic           clk,
    input  logic           we,
    input  logic [A_W-1:0] waddr,
    input  logic [W-1:0]   wdata,
    input  logic [A_W-1:0] raddr,
    output logic [W-1:0]   rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* bench/tb_polite_host_frontier_scheduler.sv */
`timescale 1ns / 1ps
module tb_polite_host_frontier_scheduler;
    import pfs_pkg::*;

    localparam int  CYCLE_LIMIT  = 4000000;
    localparam int  SETTLE_WAIT  = 700;
    localparam int  CALM_TAIL    = 300;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] host;
    } url_t;

    // one word of the input channel, or a delay write between phases
    typedef struct {
        bit          is_cfg;
        logic [31:0] delay;
        logic        op;
        logic [31:0] item_id;
        logic [15:0] host_key;
        logic [7:0]  priority_req;
        logic        item_ok;
        logic [47:0] now_time;
    } job_t;

    typedef struct {
        status_t     status;
        logic [31:0] id;
        logic [15:0] host;
        logic [47:0] fetch_time;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [31:0] item_id = '0;
    logic [15:0] host_key = '0;
    logic [7:0]  priority_req = '0;
    logic        item_ok = 1'b0;
    logic [47:0] now_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] out_item_id;
    logic [15:0] out_host_key;
    logic [47:0] fetch_time;

    polite_host_frontier_scheduler u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .item_id(item_id), .host_key(host_key),
        .priority_req(priority_req), .item_ok(item_ok), .now_time(now_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_item_id(out_item_id),
        .out_host_key(out_host_key), .fetch_time(fetch_time)
    );

    // frontier mirror
    url_t        front_fifo [NUM_FRONT][$];
    url_t        host_fifo  [NUM_BACK][$];
    logic [15:0] host_owner [NUM_BACK];
    logic [47:0] host_ready [NUM_BACK];
    logic [31:0] delay_now = DELAY_RESET;

    job_t     pending_jobs[$];
    outcome_t due_results[$];
    job_t     cur_job;
    int       mismatches = 0;
    int       cycles = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       settle = 0;

    initial begin
        for (int b = 0; b < NUM_BACK; b++)
        begin
            host_owner[b] = '0;
            host_ready[b] = '0;
        end
    end

    initial begin
        forever #2 clk = ~clk;
    end

    // move front items into per-host queues
    task automatic refill_hosts(input logic [47:0] now);
        int pos;
        int left;
        int tgt;
        url_t e;
        pos = NUM_FRONT;
        for (int lim = ROUTE_LIMIT; lim > 0 && pos > 0; lim--)
        begin
            pos--;
            left = front_fifo[pos].size();
            while (left > 0 && front_fifo[pos].size() > 0)
            begin
                e = front_fifo[pos].pop_front();
                left--;
                tgt = -1;
                for (int b = 0; b < NUM_BACK; b++)
                    if (tgt < 0 && host_fifo[b].size() > 0 && host_owner[b] == e.host)
                        tgt = b;
                if (tgt >= 0)
                begin
                    if (host_fifo[tgt].size() < BACK_DEPTH)
                        host_fifo[tgt].push_back(e);
                    else
                        front_fifo[pos].push_back(e);
                    continue;
                end
                for (int b = 0; b < NUM_BACK; b++)
                    if (tgt < 0 && host_fifo[b].size() == 0)
                        tgt = b;
                if (tgt < 0)
                begin
                    front_fifo[pos].push_back(e);
                    continue;
                end
                host_owner[tgt] = e.host;
                host_ready[tgt] = now;
                host_fifo[tgt].push_back(e);
            end
        end
    endtask

    function automatic bit any_scheduled();
        for (int b = 0; b < NUM_BACK; b++)
            if (host_fifo[b].size() > 0)
                return 1'b1;
        return 1'b0;
    endfunction

    // expected result of one accepted word
    task automatic schedule_word(input job_t j);
        outcome_t r;
        int best;
        url_t e;
        logic [48:0] nt;
        r = '{ST_OK, '0, '0, '0};
        best = -1;
        if (j.op == 1'b0)
        begin
            if (!j.item_ok || j.priority_req >= NUM_FRONT)
                r.status = ST_BAD;
            else if (front_fifo[j.priority_req].size() >= FRONT_DEPTH)
                r.status = ST_FULL;
            else
                front_fifo[j.priority_req].push_back('{j.item_id, j.host_key});
        end
        else
        begin
            if (!any_scheduled())
                refill_hosts(j.now_time);
            if (!any_scheduled())
                r.status = ST_EMPTY;
            else
            begin
                for (int b = 0; b < NUM_BACK; b++)
                    if (host_fifo[b].size() > 0 &&
                        (best < 0 || host_ready[b] < host_ready[best]))
                        best = b;
                e = host_fifo[best].pop_front();
                r.id = e.id;
                r.host = e.host;
                r.fetch_time = host_ready[best];
                if (host_fifo[best].size() == 0)
                begin
                    host_owner[best] = '0;
                    refill_hosts(j.now_time);
                end
                else
                begin
                    nt = {1'b0, host_ready[best]} + delay_now;
                    host_ready[best] = nt[48] ? TIME_MAX : nt[47:0];
                end
            end
        end
        due_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic job_t make_word(input logic o, input logic [31:0] id,
                                       input logic [15:0] h, input logic [7:0] p,
                                       input logic ok, input logic [47:0] t);
        job_t j;
        j = '{1'b0, '0, o, id, h, p, ok, t};
        return j;
    endfunction

    // random word, mostly well-formed pushes over a small host pool
    function automatic job_t random_word(input bit late_clock);
        job_t j;
        logic [47:0] t;
        t = 48'({$urandom, $urandom});
        if (late_clock)
            t = 48'hFFFF_FFF0_0000 | 48'($urandom_range(0, 32'hFFFFF));
        else if ($urandom_range(0, 15) == 0)
            t = TIME_MAX;
        j = make_word($urandom_range(0, 99) < 45, $urandom,
                      ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 11)),
                      ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, NUM_FRONT - 1)),
                      $urandom_range(0, 15) != 0, t);
        return j;
    endfunction

    task automatic add_delay_write(input logic [31:0] d);
        job_t j;
        j = make_word(1'b0, '0, '0, '0, 1'b0, '0);
        j.is_cfg = 1'b1;
        j.delay = d;
        pending_jobs.push_back(j);
    endtask

    // driver: one word at a time, delay writes only once the block is idle
    always @(posedge clk)
    begin
        logic        nv;
        logic        wr;
        logic [31:0] wd;
        if (rst_n)
        begin
            nv = in_valid;
            wr = 1'b0;
            wd = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                schedule_word(cur_job);
                nv = 1'b0;
                if (pending_jobs.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            if (!nv && send_gap > 0)
                send_gap--;
            else if (!nv && pending_jobs.size() > 0)
            begin
                if (pending_jobs[0].is_cfg)
                begin
                    if (due_results.size() != 0)
                        settle = 0;
                    else if (settle >= SETTLE_WAIT)
                    begin
                        wr = 1'b1;
                        wd = pending_jobs[0].delay;
                        delay_now = wd;
                        void'(pending_jobs.pop_front());
                        settle = 0;
                    end
                    else
                        settle++;
                end
                else
                begin
                    cur_job = pending_jobs.pop_front();
                    op <= cur_job.op;
                    item_id <= cur_job.item_id;
                    host_key <= cur_job.host_key;
                    priority_req <= cur_job.priority_req;
                    item_ok <= cur_job.item_ok;
                    now_time <= cur_job.now_time;
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
            cfg_wr_en <= wr;
            cfg_wr_data <= wd;
        end
    end

    // monitor: random stall bursts, compare against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t w;
        logic ns;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report_mismatch("unexpected word", {46'd0, status}, '0);
                else
                begin
                    w = due_results.pop_front();
                    if (status !== w.status)
                        report_mismatch("status", status, w.status);
                    if (out_item_id !== w.id)
                        report_mismatch("out_item_id", out_item_id, w.id);
                    if (out_host_key !== w.host)
                        report_mismatch("out_host_key", out_host_key, w.host);
                    if (fetch_time !== w.fetch_time)
                        report_mismatch("fetch_time", fetch_time, w.fetch_time);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ns = 1'b1;
            end
            else if (pending_jobs.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                ns = 1'b1;
            end
            else
                ns = 1'b0;
            out_stall <= ns;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("polite_host_frontier_scheduler test failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] phase_delay [4];
        phase_delay = '{32'd0, 32'hFFFF_FFFF, 32'd5000000, 32'd0};
        phase_delay[3] = $urandom_range(1, 1000);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, rejects, extreme fields, a full front queue
        pending_jobs.push_back(make_word(1'b1, '1, '1, '1, 1'b1, '0));
        pending_jobs.push_back(make_word(1'b0, 32'h1, 16'h1, 8'd3, 1'b0, '0));
        pending_jobs.push_back(make_word(1'b0, 32'h2, 16'h2, 8'd8, 1'b1, '0));
        pending_jobs.push_back(make_word(1'b0, 32'h3, 16'h3, 8'hFF, 1'b1, '0));
        pending_jobs.push_back(make_word(1'b0, '1, '1, 8'd7, 1'b1, TIME_MAX));
        for (int k = 0; k <= FRONT_DEPTH; k++)
            pending_jobs.push_back(make_word(1'b0, 32'(k), 16'(k % 3), 8'd0, 1'b1, '0));
        pending_jobs.push_back(make_word(1'b1, '0, '0, '0, 1'b0, TIME_MAX));
        pending_jobs.push_back(make_word(1'b1, '0, '0, '0, 1'b0, '0));
        pending_jobs.push_back(make_word(1'b1, '1, '1, '1, 1'b1, 48'h1234));

        // random phases at several delay settings
        for (int ph = 0; ph < 4; ph++)
        begin
            add_delay_write(phase_delay[ph]);
            for (int k = 0; k < 482; k++)
                pending_jobs.push_back(random_word(ph == 1));
        end

        wait (pending_jobs.size() == 0 && !in_valid && due_results.size() == 0);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("polite_host_frontier_scheduler test passed");
        else
            $display("polite_host_frontier_scheduler test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/pfs_pkg.sv
sv/pfs_ram.sv
sv/polite_host_frontier_scheduler.sv
bench/tb_polite_host_frontier_scheduler.sv
